[sv/cstsu_pkg.sv]
// cstsu_pkg: shared widths, controller states and the command/status structs
// used by the safe time search controller, datapath and top level
// no dependencies
package cstsu_pkg;

   // field widths
   localparam int SPEED_W   = 14;
   localparam int IDX_W     = 14;
   localparam int NUM_W     = IDX_W + 2;
   localparam int PROD_W    = NUM_W + SPEED_W;
   localparam int WIT_NUM_W = 15;
   localparam int WIT_DEN_W = 16;
   localparam int RUNNERS   = 4;
   localparam int SEL_W     = 2;

   // largest meaningful speed
   localparam int MAX_SPEED = 16383;

   // stream payload widths
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 32;

   // runner used for the first compare of each pass
   localparam logic [SEL_W-1:0] FIRST_SEL = SEL_W'(1);
   localparam logic [SEL_W-1:0] LAST_SEL  = SEL_W'(RUNNERS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic             load;
      logic             scan;
      logic [SEL_W-1:0] sel;
      logic             advance;
      logic             done;
      logic             hit;
      logic             out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic bad_speed;
      logic over_half;
      logic meet;
      logic out_free;
   } status_type;

endpackage

[sv/cstsu_ctrl.sv]
// cstsu_ctrl: sequencer for the interval sweep, one runner compare per scan cycle
// depends on cstsu_pkg
module cstsu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  cstsu_pkg::status_type status,
   output cstsu_pkg::cmd_type    cmd
);

   cstsu_pkg::state_type state_ff, state_in;
   logic [cstsu_pkg::SEL_W-1:0] sel_ff, sel_in;

   // state and runner select registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cstsu_pkg::ST_IDLE;
         sel_ff   <= cstsu_pkg::FIRST_SEL;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      case (state_ff)
         cstsu_pkg::ST_IDLE: begin
            sel_in = cstsu_pkg::FIRST_SEL;
            if (req_tvalid) begin
               state_in = cstsu_pkg::ST_SCAN;
            end
         end
         cstsu_pkg::ST_SCAN: begin
            if (sel_ff == cstsu_pkg::LAST_SEL) begin
               state_in = cstsu_pkg::ST_CHECK;
            end else begin
               sel_in = sel_ff + cstsu_pkg::SEL_W'(1);
            end
         end
         cstsu_pkg::ST_CHECK: begin
            sel_in = cstsu_pkg::FIRST_SEL;
            if (status.bad_speed || status.over_half || status.meet) begin
               state_in = cstsu_pkg::ST_FINISH;
            end else begin
               state_in = cstsu_pkg::ST_SCAN;
            end
         end
         cstsu_pkg::ST_FINISH: begin
            if (status.out_free) begin
               state_in = cstsu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cstsu_pkg::ST_IDLE;
         end
      endcase
   end

   // command outputs
   always_comb begin
      cmd        = '0;
      cmd.sel    = sel_ff;
      req_tready = 1'b0;
      case (state_ff)
         cstsu_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         cstsu_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         cstsu_pkg::ST_CHECK: begin
            if (status.bad_speed || status.over_half) begin
               cmd.done = 1'b1;
            end else if (status.meet) begin
               cmd.done = 1'b1;
               cmd.hit  = 1'b1;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         cstsu_pkg::ST_FINISH: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

`ifndef ASSERT_OFF
   // a result is only handed over after a pass ended the search, and handing it over returns the sequencer to idle
   a_out_after_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> state_ff == cstsu_pkg::ST_IDLE)
      else $error("result load did not return the sequencer to idle");
`endif

endmodule

[sv/cstsu_dp.sv]
// cstsu_dp: runner speeds, interval indices, running max/min of the interval
// ends with cross-multiply compares, and the result register
// depends on cstsu_pkg
module cstsu_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [cstsu_pkg::REQ_DATA_W-1:0]    req_data,
   input  cstsu_pkg::cmd_type                  cmd,
   output cstsu_pkg::status_type               status,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_found,
   output logic [cstsu_pkg::WIT_NUM_W-1:0]     rsp_num,
   output logic [cstsu_pkg::WIT_DEN_W-1:0]     rsp_den
);

   localparam int SW = cstsu_pkg::SPEED_W;
   localparam int NW = cstsu_pkg::NUM_W;
   localparam int PW = cstsu_pkg::PROD_W;

   logic [SW-1:0]               spd_ff [cstsu_pkg::RUNNERS];
   logic [cstsu_pkg::IDX_W-1:0] idx_ff [cstsu_pkg::RUNNERS];
   logic [NW-1:0]               low_num_ff, up_num_ff;
   logic [SW-1:0]               low_den_ff, up_den_ff;
   logic [cstsu_pkg::SEL_W-1:0] first_ff;
   logic                        hit_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_found_ff;
   logic [cstsu_pkg::WIT_NUM_W-1:0] rsp_num_ff;
   logic [cstsu_pkg::WIT_DEN_W-1:0] rsp_den_ff;

   logic [NW-1:0] cur_lo_num, cur_hi_num;
   logic [SW-1:0] cur_den;
   logic [NW-1:0] base_lo_num, base_up_num;
   logic [SW-1:0] base_lo_den, base_up_den;
   logic [cstsu_pkg::SEL_W-1:0] base_first;
   logic [NW-1:0] a_xn, a_yn;
   logic [SW-1:0] a_xd, a_yd;
   logic [PW-1:0] a_left, a_right, b_left, b_right;
   logic          a_below, b_below;
   logic          bad_speed;

   // interval ends of the runner under compare
   assign cur_lo_num = {idx_ff[cmd.sel], 2'b01};
   assign cur_hi_num = {idx_ff[cmd.sel], 2'b11};
   assign cur_den    = spd_ff[cmd.sel];

   // first compare of a pass starts from runner zero's interval
   always_comb begin
      if (cmd.sel == cstsu_pkg::FIRST_SEL) begin
         base_lo_num = {idx_ff[0], 2'b01};
         base_lo_den = spd_ff[0];
         base_up_num = {idx_ff[0], 2'b11};
         base_up_den = spd_ff[0];
         base_first  = '0;
      end else begin
         base_lo_num = low_num_ff;
         base_lo_den = low_den_ff;
         base_up_num = up_num_ff;
         base_up_den = up_den_ff;
         base_first  = first_ff;
      end
   end

   // compare pair a: lower ends while scanning, upper min against lower max at check
   always_comb begin
      if (cmd.scan) begin
         a_xn = base_lo_num;
         a_xd = base_lo_den;
         a_yn = cur_lo_num;
         a_yd = cur_den;
      end else begin
         a_xn = up_num_ff;
         a_xd = up_den_ff;
         a_yn = low_num_ff;
         a_yd = low_den_ff;
      end
   end

   assign a_left  = PW'(a_xn) * PW'(a_yd);
   assign a_right = PW'(a_yn) * PW'(a_xd);
   assign a_below = a_left < a_right;

   // compare pair b: upper ends while scanning
   assign b_left  = PW'(cur_hi_num) * PW'(base_up_den);
   assign b_right = PW'(base_up_num) * PW'(cur_den);
   assign b_below = b_left < b_right;

   // zero or out of range speed ends the search with no result
   always_comb begin
      bad_speed = 1'b0;
      for (int i = 0; i < cstsu_pkg::RUNNERS; i++) begin
         if (spd_ff[i] == '0 || spd_ff[i] > SW'(cstsu_pkg::MAX_SPEED)) begin
            bad_speed = 1'b1;
         end
      end
   end

   // status back to the sequencer
   assign status.bad_speed = bad_speed;
   assign status.over_half = low_num_ff > {1'b0, low_den_ff, 1'b0};
   assign status.meet      = !a_below;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // speeds and interval indices
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < cstsu_pkg::RUNNERS; i++) begin
            spd_ff[i] <= req_data[i*SW +: SW];
            idx_ff[i] <= '0;
         end
      end else if (cmd.advance) begin
         idx_ff[first_ff] <= idx_ff[first_ff] + cstsu_pkg::IDX_W'(1);
      end
   end

   // running lower max and upper min
   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         if (a_below) begin
            low_num_ff <= cur_lo_num;
            low_den_ff <= cur_den;
         end else begin
            low_num_ff <= base_lo_num;
            low_den_ff <= base_lo_den;
         end
         if (b_below) begin
            up_num_ff <= cur_hi_num;
            up_den_ff <= cur_den;
            first_ff  <= cmd.sel;
         end else begin
            up_num_ff <= base_up_num;
            up_den_ff <= base_up_den;
            first_ff  <= base_first;
         end
      end
   end

   // search outcome
   always_ff @(posedge clock) begin
      if (cmd.done) begin
         hit_ff <= cmd.hit;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_found_ff <= hit_ff;
         if (hit_ff) begin
            rsp_num_ff <= low_num_ff[cstsu_pkg::WIT_NUM_W-1:0];
            rsp_den_ff <= {low_den_ff, 2'b00};
         end else begin
            rsp_num_ff <= '0;
            rsp_den_ff <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_num   = rsp_num_ff;
   assign rsp_den   = rsp_den_ff;

`ifndef ASSERT_OFF
   // a loaded result is offered in the next cycle
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded result not offered");

   // a miss carries a zero witness
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_num_ff == '0 && rsp_den_ff == '0)
      else $error("miss with nonzero witness");

   // a witness lies in (0, 1/2]
   a_hit_half: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |->
         rsp_den_ff != '0 && {rsp_num_ff, 1'b0} <= {1'b0, rsp_den_ff})
      else $error("witness outside the first half unit");

   // an advance only follows a full scan pass
   a_adv_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.advance |-> $past(cmd.scan) && $past(cmd.sel) == cstsu_pkg::LAST_SEL)
      else $error("index advanced without a completed scan");
`endif

endmodule

[sv/common_safe_time_search_unit.sv]
// common_safe_time_search_unit: earliest common safe time of four runners
// the search runs in passes; passes = 1 + number of index advances, bounded by about
// the sum of the speeds over two; each pass scans runners one to three through the
// shared cross-multiply compare pairs, then makes one check
// one item at a time; the next item is taken while a result waits in the output register
// reset: synchronous active high, clears the sequencer and the result valid flag
module common_safe_time_search_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // speed_a[13:0], speed_b[27:14], speed_c[41:28], speed_d[55:42]
   input  logic [cstsu_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // witness_num[14:0], witness_den[30:15], zero [31]
   output logic [cstsu_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // found[0]
   output logic                                rsp_tuser
);

   cstsu_pkg::cmd_type    cmd;
   cstsu_pkg::status_type status;
   logic [cstsu_pkg::WIT_NUM_W-1:0] rsp_num;
   logic [cstsu_pkg::WIT_DEN_W-1:0] rsp_den;

   // sequencer
   cstsu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath
   cstsu_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_found (rsp_tuser),
      .rsp_num   (rsp_num),
      .rsp_den   (rsp_den)
   );

   // pack the result item
   assign rsp_tdata = {1'b0, rsp_den, rsp_num};

endmodule

[verif/tb_top.sv]
// tb_top: self-checking testbench for common_safe_time_search_unit
// drives speed items over the req_ stream, predicts each result and checks rsp_ items
// depends on cstsu_pkg and common_safe_time_search_unit
module tb_top;

   // run shape
   localparam int RANDOM_ITEMS   = 930;
   localparam int QUIET_TAIL     = 100;
   localparam int HOLD_AT        = 200;
   localparam int HOLD_CYCLES    = 3000;
   localparam int WATCHDOG_LIMIT = 600000;
   localparam int DRAIN_CYCLES   = 64;
   localparam int MAX_REPORTS    = 10;

   // one input item, speed_a in the lowest bits
   typedef struct packed {
      logic [cstsu_pkg::SPEED_W-1:0] speed_d;
      logic [cstsu_pkg::SPEED_W-1:0] speed_c;
      logic [cstsu_pkg::SPEED_W-1:0] speed_b;
      logic [cstsu_pkg::SPEED_W-1:0] speed_a;
   } speed_set_type;

   // one result item
   typedef struct packed {
      logic                            found;
      logic [cstsu_pkg::WIT_NUM_W-1:0] witness_num;
      logic [cstsu_pkg::WIT_DEN_W-1:0] witness_den;
   } search_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [cstsu_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [cstsu_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                             rsp_tuser;

   speed_set_type     speed_q[$];
   search_result_type witness_q[$];

   int  total_items = 0;
   int  items_in = 0;
   int  items_out = 0;
   int  found_count = 0;
   int  mismatches = 0;
   int  stall_cycles = 0;
   int  req_gap = 0;
   int  rsp_gap = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  req_taken = 1'b0;

   common_safe_time_search_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock, period 2
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // earliest common safe time at most one half, swept interval by interval
   function automatic search_result_type safe_time_predict(speed_set_type s);
      logic [63:0]       spd [cstsu_pkg::RUNNERS];
      logic [63:0]       idx [cstsu_pkg::RUNNERS];
      logic [63:0]       lo_n, lo_d, hi_n, hi_d;
      logic [63:0]       lmax_n, lmax_d, umin_n, umin_d;
      int                first;
      bit                done;
      search_result_type r;
      r = '0;
      done = 1'b0;
      spd[0] = s.speed_a;
      spd[1] = s.speed_b;
      spd[2] = s.speed_c;
      spd[3] = s.speed_d;
      for (int i = 0; i < cstsu_pkg::RUNNERS; i++) begin
         idx[i] = 0;
         // zero or oversized speed gives not found
         if (spd[i] == 0 || spd[i] > cstsu_pkg::MAX_SPEED)
            done = 1'b1;
      end
      while (!done) begin
         lmax_n = 4 * idx[0] + 1;
         lmax_d = 4 * spd[0];
         umin_n = 4 * idx[0] + 3;
         umin_d = lmax_d;
         first  = 0;
         // strict compares keep the earliest runner on ties
         for (int i = 1; i < cstsu_pkg::RUNNERS; i++) begin
            lo_n = 4 * idx[i] + 1;
            lo_d = 4 * spd[i];
            hi_n = 4 * idx[i] + 3;
            hi_d = lo_d;
            if (lmax_n * lo_d < lo_n * lmax_d) begin
               lmax_n = lo_n;
               lmax_d = lo_d;
            end
            if (hi_n * umin_d < umin_n * hi_d) begin
               umin_n = hi_n;
               umin_d = hi_d;
               first  = i;
            end
         end
         if (lmax_d < 2 * lmax_n) begin
            // largest lower end past one half
            done = 1'b1;
         end else if (!(umin_n * lmax_d < lmax_n * umin_d)) begin
            r.found       = 1'b1;
            r.witness_num = lmax_n[cstsu_pkg::WIT_NUM_W-1:0];
            r.witness_den = lmax_d[cstsu_pkg::WIT_DEN_W-1:0];
            done = 1'b1;
         end else begin
            idx[first] = idx[first] + 1;
         end
      end
      return r;
   endfunction

   task automatic queue_speeds(int a, int b, int c, int d);
      speed_set_type s;
      s.speed_a = cstsu_pkg::SPEED_W'(a);
      s.speed_b = cstsu_pkg::SPEED_W'(b);
      s.speed_c = cstsu_pkg::SPEED_W'(c);
      s.speed_d = cstsu_pkg::SPEED_W'(d);
      speed_q = {speed_q, s};
   endtask

   function automatic int any_speed(int hi);
      return $urandom_range(1, hi);
   endfunction

   // sender: new item at the falling edge, random gaps between items before the quiet tail
   always @(negedge clock) begin : req_driver
      logic                             v;
      logic [cstsu_pkg::REQ_DATA_W-1:0] d;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         v = req_tvalid;
         d = req_tdata;
         if (v && req_taken)
            v = 1'b0;
         if (!v) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (speed_q.size() > 0) begin
               if (items_in < total_items - QUIET_TAIL && $urandom_range(0, 7) == 0) begin
                  req_gap = $urandom_range(1, 13) - 1;
               end else begin
                  d = speed_q.pop_front();
                  v = 1'b1;
               end
            end
         end
         req_tvalid <= v;
         req_tdata  <= d;
      end
   end

   // receiver: random stall bursts before the quiet tail and one long hold-off to back up the input
   always @(negedge clock) begin : rsp_driver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && items_in >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else if (items_in < total_items - QUIET_TAIL && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(1, 13) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: predict on each accepted item, check each accepted result
   always @(posedge clock) begin : rsp_monitor
      search_result_type want;
      bit                rsp_taken;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_tvalid && req_tready;
         rsp_taken = rsp_tvalid && rsp_tready;
         if (req_taken) begin
            want = safe_time_predict(speed_set_type'(req_tdata));
            if (want.found)
               found_count++;
            witness_q = {witness_q, want};
            items_in++;
         end
         if (rsp_taken) begin
            items_out++;
            if (witness_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result item: found=%0d num=%0d den=%0d pad=%0d",
                           rsp_tuser, rsp_tdata[14:0], rsp_tdata[30:15], rsp_tdata[31]);
            end else begin
               want = witness_q.pop_front();
               if (rsp_tuser !== want.found || rsp_tdata[14:0] !== want.witness_num ||
                   rsp_tdata[30:15] !== want.witness_den || rsp_tdata[31] !== 1'b0) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("result %0d mismatch: expected found=%0d num=%0d den=%0d, %s",
                              items_out, want.found, want.witness_num, want.witness_den,
                              $sformatf("got found=%0d num=%0d den=%0d pad=%0d", rsp_tuser,
                                        rsp_tdata[14:0], rsp_tdata[30:15], rsp_tdata[31]));
               end
            end
         end
         // watchdog on cycles with no item moving on either side
         if (req_taken || rsp_taken) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
               $display("watchdog: no item moved for %0d cycles", stall_cycles);
               $display("FAILURE");
               $finish;
            end
         end
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      int pick;
      int slot;
      int spd [cstsu_pkg::RUNNERS];
      // directed: extremes, zero speed in each slot, ties, a sweep that finds nothing
      queue_speeds(16383, 16383, 16383, 16383);
      queue_speeds(1, 1, 1, 1);
      queue_speeds(0, 0, 0, 0);
      queue_speeds(0, 5, 7, 9);
      queue_speeds(5, 0, 7, 9);
      queue_speeds(5, 7, 0, 9);
      queue_speeds(5, 7, 9, 0);
      queue_speeds(0, 16383, 16383, 16383);
      queue_speeds(1, 2, 3, 4);
      queue_speeds(4, 3, 2, 1);
      queue_speeds(1, 1, 1, 2);
      queue_speeds(2, 2, 3, 5);
      queue_speeds(3, 5, 3, 5);
      queue_speeds(7, 7, 7, 3);
      queue_speeds(1, 2, 4, 8);
      queue_speeds(16383, 1, 1, 1);
      queue_speeds(1, 2, 3, 16383);
      queue_speeds(16383, 16382, 16381, 16380);
      queue_speeds(8192, 4096, 2048, 1024);
      queue_speeds(10922, 5461, 3, 1);
      // random: mostly modest speeds, some tiny ones for ties, a few wide or zero
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         slot = $urandom_range(0, cstsu_pkg::RUNNERS - 1);
         for (int i = 0; i < cstsu_pkg::RUNNERS; i++)
            spd[i] = (pick < 20) ? any_speed(31) : any_speed(255);
         if (pick < 4)
            spd[slot] = 0;
         else if (pick < 6)
            spd[slot] = any_speed(16383);
         queue_speeds(spd[0], spd[1], spd[2], spd[3]);
      end
      total_items = speed_q.size();

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      wait (items_in == total_items);
      while (witness_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d of %0d speed items, %0d with a safe time found, %0d without",
               items_out, total_items, found_count, total_items - found_count);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/cstsu_pkg.sv
sv/cstsu_ctrl.sv
sv/cstsu_dp.sv
sv/common_safe_time_search_unit.sv
verif/tb_top.sv
